// ===== hdl/auto_scaling_ema_filter_unit_macros.svh =====
// assertion macros for the auto-scaling ema filter
`ifndef AUTO_SCALING_EMA_FILTER_UNIT_MACROS_SVH
`define AUTO_SCALING_EMA_FILTER_UNIT_MACROS_SVH

// consequence must hold in the same cycle
`define ASEF_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the next cycle
`define ASEF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/asef_pkg.sv =====
// shared types and constants for the auto-scaling ema filter
package asef_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int TS_W        = 48;
    localparam int SUM_W       = 48;
    localparam int CFG_W       = 16;
    localparam int FACTOR_W    = 32;
    localparam int SCALE_W     = 32;
    localparam int DIV_W       = 48;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int CFG_INDEX_W = 2;
    localparam int PROD_W      = 64;
    localparam int LIMIT_W     = 26;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_INTERVAL  = 2'd1;

    localparam logic [LIMIT_W-1:0] MS_PER_S  = 26'd1000;
    localparam logic [DIV_W-1:0]   ONE_Q31   = 48'h0000_8000_0000;
    localparam logic [PROD_W-1:0]  HALF_Q30  = 64'h0000_0000_2000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [TS_W-1:0]            timestamp_ms;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ema_result;
        logic                       warmed_up;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INTERVAL,
        ST_MEAN_SETUP,
        ST_MEAN_WAIT,
        ST_FACT_MUL,
        ST_FACT_SETUP,
        ST_FACT_WAIT,
        ST_EMA_MUL,
        ST_EMA_ADD,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/asef_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
module asef_divider
    import asef_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/auto_scaling_ema_filter_unit.sv =====
// Auto-scaling EMA filter: takes one Q16.16 sample word with a millisecond timestamp and
// returns one result word (filter value and warmed-up flag). During warm-up the result is
// the rounded running mean; afterwards an EMA with factor 2/(window_length*scale+1) in Q2.30,
// where scale is the sample count of the last finished rate interval. One word is in work
// at a time and sample_stall is high until its result is loaded into the output register.
// A warm-up word and a word that recomputes the factor each wait for the shared 48-bit
// restoring divider, which produces one quotient bit per cycle; a plain EMA word does not
// use it. cfg_ready is always high.
`include "auto_scaling_ema_filter_unit_macros.svh"

module auto_scaling_ema_filter_unit
    import asef_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  in_t                    sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output out_t                   result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    state_t state_reg, state_next;

    in_t                       item_reg, item_next;
    logic [CFG_W-1:0]          wl_reg, wl_next;
    logic [CFG_W-1:0]          sis_reg, sis_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [CFG_W-1:0]          wcount_reg, wcount_next;
    logic signed [SAMPLE_W-1:0] filter_reg, filter_next;
    logic [FACTOR_W-1:0]       factor_reg, factor_next;
    logic                      stale_reg, stale_next;
    logic [SCALE_W-1:0]        scale_reg, scale_next;
    logic [TS_W-1:0]           start_ts_reg, start_ts_next;
    logic [SCALE_W-1:0]        icount_reg, icount_next;
    logic [DIV_W-1:0]          den_reg, den_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic                      neg_reg, neg_next;
    out_t                      result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic sample_accept;
    logic cfg_write;
    logic slot_free;

    // rate interval
    logic [TS_W-1:0]    start_eff;
    logic [SCALE_W-1:0] cnt_inc;
    logic [TS_W:0]      ts_diff;
    logic [LIMIT_W-1:0] limit_ms;
    logic               interval_end;
    logic               scale_change;
    logic               warm_step;

    // warm-up sum
    logic [SUM_W:0]          sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic [SUM_W-1:0]        sum_mag;

    // mean result clamp
    logic [DIV_W-1:0]           q_mean;
    logic signed [SAMPLE_W-1:0] mean_val;

    // factor
    logic [DIV_W-1:0] den_prod;

    // ema
    logic [SAMPLE_W:0]          ema_diff;
    logic [SAMPLE_W:0]          ema_mag;
    logic [PROD_W-1:0]          ema_prod;
    logic [PROD_W-1:0]          ema_round;
    logic [SAMPLE_W+2:0]        ema_q;
    logic signed [SAMPLE_W+2:0] ema_sum;
    logic signed [SAMPLE_W-1:0] ema_val;

    assign sample_accept = sample_valid && !sample_stall;
    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid && cfg_ready;
    assign slot_free     = !result_valid_reg || !result_stall;

    assign sample_stall  = (state_reg != ST_IDLE);
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

    assign start_eff    = (start_ts_reg == '0) ? item_reg.timestamp_ms : start_ts_reg;
    assign cnt_inc      = (icount_reg == '1) ? icount_reg : icount_reg + 1'b1;
    assign ts_diff      = {1'b0, item_reg.timestamp_ms} - {1'b0, start_eff};
    assign limit_ms     = LIMIT_W'({10'd0, sis_reg} * MS_PER_S);
    // signed time difference, so an older timestamp never closes the interval
    assign interval_end = $signed(ts_diff) > $signed({{(TS_W + 1 - LIMIT_W){1'b0}}, limit_ms});
    assign scale_change = interval_end && (scale_reg != cnt_inc);
    assign warm_step    = wcount_reg < wl_reg;

    assign sum_wide = {sum_reg[SUM_W-1], sum_reg}
                    + {{(SUM_W + 1 - SAMPLE_W){item_reg.sample_value[SAMPLE_W-1]}},
                       item_reg.sample_value};
    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // round-half-away mean, sign applied after the unsigned divide
    assign q_mean = div_rsp.quotient;
    always_comb
    begin
        if (!sum_reg[SUM_W-1])
            mean_val = (q_mean > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                         : $signed(q_mean[SAMPLE_W-1:0]);
        else
            mean_val = (q_mean > DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                          : $signed(-q_mean[SAMPLE_W-1:0]);
    end

    assign den_prod = DIV_W'(wl_reg) * DIV_W'(scale_reg);

    assign ema_diff = {item_reg.sample_value[SAMPLE_W-1], item_reg.sample_value}
                    - {filter_reg[SAMPLE_W-1], filter_reg};
    assign ema_mag  = ema_diff[SAMPLE_W] ? -ema_diff : ema_diff;
    assign ema_prod = PROD_W'(ema_mag) * PROD_W'(factor_reg);

    assign ema_round = prod_reg + HALF_Q30;
    assign ema_q     = {1'b0, ema_round[PROD_W-1:30]};
    assign ema_sum   = $signed({{3{filter_reg[SAMPLE_W-1]}}, filter_reg})
                     + (neg_reg ? $signed(-ema_q) : $signed(ema_q));
    always_comb
    begin
        if (ema_sum > $signed(35'sh0_7FFF_FFFF))
            ema_val = 32'sh7FFF_FFFF;
        else if (ema_sum < $signed(35'sh7_8000_0000))
            ema_val = 32'sh8000_0000;
        else
            ema_val = ema_sum[SAMPLE_W-1:0];
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (sample_accept)
                    state_next = ST_INTERVAL;
            ST_INTERVAL:
                if (warm_step)
                    state_next = ST_MEAN_SETUP;
                else if (stale_reg || scale_change)
                    state_next = ST_FACT_MUL;
                else
                    state_next = ST_EMA_MUL;
            ST_MEAN_SETUP:
                state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
                if (div_rsp.done)
                    state_next = ST_DONE;
            ST_FACT_MUL:
                state_next = ST_FACT_SETUP;
            ST_FACT_SETUP:
                state_next = ST_FACT_WAIT;
            ST_FACT_WAIT:
                if (div_rsp.done)
                    state_next = ST_EMA_MUL;
            ST_EMA_MUL:
                state_next = ST_EMA_ADD;
            ST_EMA_ADD:
                state_next = ST_DONE;
            ST_DONE:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs to the divider
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            ST_MEAN_SETUP:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_mag + DIV_W'(wcount_reg >> 1);
                div_req.divisor  = DIV_W'(wcount_reg);
            end
            ST_FACT_SETUP:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ONE_Q31 + (den_reg >> 1);
                div_req.divisor  = den_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        item_next         = item_reg;
        wl_next           = wl_reg;
        sis_next          = sis_reg;
        sum_next          = sum_reg;
        wcount_next       = wcount_reg;
        filter_next       = filter_reg;
        factor_next       = factor_reg;
        stale_next        = stale_reg;
        scale_next        = scale_reg;
        start_ts_next     = start_ts_reg;
        icount_next       = icount_reg;
        den_next          = den_reg;
        prod_next         = prod_reg;
        neg_next          = neg_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH:
                begin
                    wl_next    = cfg_data;
                    stale_next = 1'b1;
                end
                REG_SCALE_INTERVAL:
                    sis_next = cfg_data;
                default:
                    sis_next = sis_reg;
            endcase
        end

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
                if (sample_accept)
                    item_next = sample;
            ST_INTERVAL:
            begin
                if (interval_end)
                begin
                    stale_next    = stale_reg || scale_change;
                    scale_next    = cnt_inc;
                    icount_next   = '0;
                    start_ts_next = item_reg.timestamp_ms;
                end
                else
                begin
                    icount_next   = cnt_inc;
                    start_ts_next = start_eff;
                end
                if (warm_step)
                begin
                    sum_next    = sum_sat;
                    wcount_next = wcount_reg + 1'b1;
                end
            end
            ST_MEAN_WAIT:
                if (div_rsp.done)
                    filter_next = mean_val;
            ST_FACT_MUL:
                den_next = den_prod + 1'b1;
            ST_FACT_WAIT:
                if (div_rsp.done)
                begin
                    factor_next = div_rsp.quotient[FACTOR_W-1:0];
                    stale_next  = 1'b0;
                end
            ST_EMA_MUL:
            begin
                prod_next = ema_prod;
                neg_next  = ema_diff[SAMPLE_W];
            end
            ST_EMA_ADD:
                filter_next = ema_val;
            ST_DONE:
                if (slot_free)
                begin
                    result_next.ema_result = filter_reg;
                    result_next.warmed_up  = (wcount_reg >= wl_reg);
                    result_valid_next      = 1'b1;
                end
            default:
                neg_next = neg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wl_reg           <= 16'd1;
            sis_reg          <= '0;
            sum_reg          <= '0;
            wcount_reg       <= '0;
            filter_reg       <= '0;
            factor_reg       <= '0;
            stale_reg        <= 1'b1;
            scale_reg        <= 32'd1;
            start_ts_reg     <= '0;
            icount_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            wl_reg           <= wl_next;
            sis_reg          <= sis_next;
            sum_reg          <= sum_next;
            wcount_reg       <= wcount_next;
            filter_reg       <= filter_next;
            factor_reg       <= factor_next;
            stale_reg        <= stale_next;
            scale_reg        <= scale_next;
            start_ts_reg     <= start_ts_next;
            icount_reg       <= icount_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        den_reg    <= den_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    asef_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    `ASEF_CHECK_NOW(a_div_start_idle, div_req.start, !div_rsp.busy,
        "divider restarted while busy")
    `ASEF_CHECK_NOW(a_div_done_waited, div_rsp.done,
        (state_reg == ST_MEAN_WAIT) || (state_reg == ST_FACT_WAIT),
        "divider finished with nobody waiting")
    `ASEF_CHECK_NEXT(a_factor_fresh, (state_reg == ST_FACT_WAIT) && div_rsp.done,
        !stale_reg && (state_reg == ST_EMA_MUL), "factor not marked fresh after recompute")
    `ASEF_CHECK_NEXT(a_result_loaded, (state_reg == ST_DONE) && !result_valid_reg,
        result_valid_reg && (state_reg == ST_IDLE), "free output register not loaded")

endmodule
